FILE: src/vau_pkg.sv
// ----------------------------------------------------------------------------
// vau_pkg
// Shared codes, defaults and control types of the 3D vector arithmetic unit.
// ----------------------------------------------------------------------------
package vau_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [2:0] ACT_ADD   = 3'd0;
	localparam logic [2:0] ACT_SUB   = 3'd1;
	localparam logic [2:0] ACT_SCALE = 3'd2;
	localparam logic [2:0] ACT_DOT   = 3'd3;
	localparam logic [2:0] ACT_LEN   = 3'd4;
	localparam logic [2:0] ACT_NORM  = 3'd5;

	typedef struct packed {
		logic       valid;
		logic [2:0] act;
		logic       d3;
	} ctrl_t;

endpackage

FILE: src/vau_front.sv
// ----------------------------------------------------------------------------
// vau_front
// Operand prep, multipliers, sums and rounding, then clamping of the
// add/subtract/scale/dot results. Four register stages.
// ----------------------------------------------------------------------------
module vau_front #(
	parameter int W = vau_pkg::WORD_BITS_DEF,
	parameter int F = vau_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2:0]          action,
	input  logic                three_d,
	input  logic [2:0][W-1:0]   a,
	input  logic [2:0][W-1:0]   b,
	input  logic [W-1:0]        sf,
	output vau_pkg::ctrl_t      ctrl_o,
	output logic [2*W-1:0]      sq_o,
	output logic [3:0][W-1:0]   early_o,
	output logic                flag_o,
	output logic [2:0]          neg_o,
	output logic [2:0][W-1:0]   mag_o
);

	localparam int XW = 2*W + 2;
	localparam logic signed [XW-1:0] MAXV = {{(W+3){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] MINV = {{(W+3){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [XW-1:0] HALF = {{(XW-1){1'b0}}, 1'b1} << (F-1);

	function automatic logic [W:0] sat_f(input logic signed [XW-1:0] x);
		if (x > MAXV) begin
			sat_f = {1'b1, MAXV[W-1:0]};
		end else if (x < MINV) begin
			sat_f = {1'b1, MINV[W-1:0]};
		end else begin
			sat_f = {1'b0, x[W-1:0]};
		end
	endfunction

	// stage 1
	vau_pkg::ctrl_t    ctrl_s1;
	logic [2:0][W-1:0] a_s1, m_s1, mag_s1;
	logic [2:0][W:0]   sum_s1;
	logic [2:0]        neg_s1;
	logic [2:0][W-1:0] av, bv, mv, magv;
	logic [2:0][W:0]   sumv;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			av[i] = (i == 2 && !three_d) ? '0 : a[i];
			bv[i] = (i == 2 && !three_d) ? '0 : b[i];
			unique case (action)
				vau_pkg::ACT_SCALE: mv[i] = sf;
				vau_pkg::ACT_DOT:   mv[i] = bv[i];
				default:            mv[i] = av[i];
			endcase
			if (action == vau_pkg::ACT_SUB) begin
				sumv[i] = {av[i][W-1], av[i]} - {bv[i][W-1], bv[i]};
			end else begin
				sumv[i] = {av[i][W-1], av[i]} + {bv[i][W-1], bv[i]};
			end
			magv[i] = av[i][W-1] ? (~av[i] + 1'b1) : av[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= '{valid: start, act: action, d3: three_d};
		end
	end

	always_ff @(posedge clk) begin
		a_s1   <= av;
		m_s1   <= mv;
		sum_s1 <= sumv;
		mag_s1 <= magv;
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= av[i][W-1];
		end
	end

	// stage 2: products
	vau_pkg::ctrl_t      ctrl_s2;
	logic [2:0][2*W-1:0] prod_s2;
	logic [2:0][W:0]     sum_s2;
	logic [2:0][W-1:0]   mag_s2;
	logic [2:0]          neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s2[i] <= $signed(a_s1[i]) * $signed(m_s1[i]);
		end
		sum_s2 <= sum_s1;
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
	end

	// stage 3: sums and rounding
	vau_pkg::ctrl_t     ctrl_s3;
	logic [2:0][XW-1:0] rnd_s3;
	logic [XW-1:0]      dot_s3;
	logic [2*W-1:0]     sq_s3;
	logic [2:0][W:0]    sum_s3;
	logic [2:0][W-1:0]  mag_s3;
	logic [2:0]         neg_s3;
	logic signed [XW-1:0] pe [3];
	logic signed [XW-1:0] rndv [3];
	logic signed [XW-1:0] tot, dotv;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pe[i]   = {{2{prod_s2[i][2*W-1]}}, prod_s2[i]};
			rndv[i] = (pe[i] + HALF) >>> F;
		end
		tot  = pe[0] + pe[1] + pe[2];
		dotv = (tot + HALF) >>> F;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rnd_s3[i] <= rndv[i];
		end
		dot_s3 <= dotv;
		sq_s3  <= tot[2*W-1:0];
		sum_s3 <= sum_s2;
		mag_s3 <= mag_s2;
		neg_s3 <= neg_s2;
	end

	// stage 4: clamp
	vau_pkg::ctrl_t    ctrl_s4;
	logic [3:0][W-1:0] early_s4, early_n;
	logic              flag_s4, flag_n;
	logic [2*W-1:0]    sq_s4;
	logic [2:0][W-1:0] mag_s4;
	logic [2:0]        neg_s4;
	logic [W:0]        t;

	always_comb begin
		early_n = '0;
		flag_n  = 1'b0;
		t       = '0;
		unique case (ctrl_s3.act)
			vau_pkg::ACT_ADD, vau_pkg::ACT_SUB: begin
				for (int i = 0; i < 3; i++) begin
					t          = sat_f({{(XW-W-1){sum_s3[i][W]}}, sum_s3[i]});
					early_n[i] = t[W-1:0];
					flag_n     = flag_n | t[W];
				end
			end
			vau_pkg::ACT_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					t          = sat_f(rnd_s3[i]);
					early_n[i] = t[W-1:0];
					flag_n     = flag_n | t[W];
				end
			end
			vau_pkg::ACT_DOT: begin
				t          = sat_f(dot_s3);
				early_n[3] = t[W-1:0];
				flag_n     = t[W];
			end
			default: begin
				early_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s4 <= '0;
		end else begin
			ctrl_s4 <= ctrl_s3;
		end
	end

	always_ff @(posedge clk) begin
		early_s4 <= early_n;
		flag_s4  <= flag_n;
		sq_s4    <= sq_s3;
		mag_s4   <= mag_s3;
		neg_s4   <= neg_s3;
	end

	assign ctrl_o  = ctrl_s4;
	assign sq_o    = sq_s4;
	assign early_o = early_s4;
	assign flag_o  = flag_s4;
	assign neg_o   = neg_s4;
	assign mag_o   = mag_s4;

endmodule

FILE: src/vau_sqrt.sv
// ----------------------------------------------------------------------------
// vau_sqrt
// Pipelined integer square root, one result bit per stage, W stages.
// Side data travels alongside unchanged.
// ----------------------------------------------------------------------------
module vau_sqrt #(
	parameter int W    = vau_pkg::WORD_BITS_DEF,
	parameter int SB_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vau_pkg::ctrl_t      ctrl_i,
	input  logic [2*W-1:0]      rad_i,
	input  logic [SB_W-1:0]     side_i,
	output vau_pkg::ctrl_t      ctrl_o,
	output logic [W-1:0]        root_o,
	output logic [SB_W-1:0]     side_o
);

	vau_pkg::ctrl_t  ctrl_s [0:W];
	logic [2*W-1:0]  rad_s  [0:W];
	logic [W+1:0]    rem_s  [0:W];
	logic [W-1:0]    root_s [0:W];
	logic [SB_W-1:0] side_s [0:W];

	assign ctrl_s[0] = ctrl_i;
	assign rad_s[0]  = rad_i;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_i;

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W+3:0] rem_n, trial, diff;

		assign rem_n = {rem_s[k], rad_s[k][2*W-1 -: 2]};
		assign trial = {2'b00, root_s[k], 2'b01};
		assign diff  = rem_n - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctrl_s[k+1] <= '0;
			end else begin
				ctrl_s[k+1] <= ctrl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k+1]  <= {rad_s[k][2*W-3:0], 2'b00};
			side_s[k+1] <= side_s[k];
			if (rem_n >= trial) begin
				rem_s[k+1]  <= diff[W+1:0];
				root_s[k+1] <= {root_s[k][W-2:0], 1'b1};
			end else begin
				rem_s[k+1]  <= rem_n[W+1:0];
				root_s[k+1] <= {root_s[k][W-2:0], 1'b0};
			end
		end
	end

	assign ctrl_o = ctrl_s[W];
	assign root_o = root_s[W];
	assign side_o = side_s[W];

endmodule

FILE: src/vau_div.sv
// ----------------------------------------------------------------------------
// vau_div
// Three-lane pipelined restoring divider for normalise: numerator prep
// stage, then one quotient bit per stage, F+1 stages.
// ----------------------------------------------------------------------------
module vau_div #(
	parameter int W    = vau_pkg::WORD_BITS_DEF,
	parameter int F    = vau_pkg::FRAC_BITS_DEF,
	parameter int SB_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vau_pkg::ctrl_t      ctrl_i,
	input  logic [W-1:0]        len_i,
	input  logic [2:0][W-1:0]   mag_i,
	input  logic [SB_W-1:0]     side_i,
	output vau_pkg::ctrl_t      ctrl_o,
	output logic [W-1:0]        len_o,
	output logic [2:0][F:0]     q_o,
	output logic [SB_W-1:0]     side_o
);

	vau_pkg::ctrl_t    ctrl_s [0:F+1];
	logic [W-1:0]      len_s  [0:F+1];
	logic [2:0][W-1:0] rem_s  [0:F+1];
	logic [2:0][F:0]   nlo_s  [0:F+1];
	logic [2:0][F:0]   q_s    [0:F+1];
	logic [SB_W-1:0]   side_s [0:F+1];
	logic [2:0][W+F-1:0] num;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = {mag_i[i], {F{1'b0}}} + (W+F)'(len_i >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s[0] <= '0;
		end else begin
			ctrl_s[0] <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		len_s[0]  <= len_i;
		side_s[0] <= side_i;
		q_s[0]    <= '0;
		for (int i = 0; i < 3; i++) begin
			rem_s[0][i] <= {1'b0, num[i][W+F-1:F+1]};
			nlo_s[0][i] <= num[i][F:0];
		end
	end

	for (genvar j = 0; j <= F; j++) begin : g_stage
		logic [2:0][W:0] rem_n, diff;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rem_n[i] = {rem_s[j][i], nlo_s[j][i][F]};
				diff[i]  = rem_n[i] - {1'b0, len_s[j]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctrl_s[j+1] <= '0;
			end else begin
				ctrl_s[j+1] <= ctrl_s[j];
			end
		end

		always_ff @(posedge clk) begin
			len_s[j+1]  <= len_s[j];
			side_s[j+1] <= side_s[j];
			for (int i = 0; i < 3; i++) begin
				nlo_s[j+1][i] <= {nlo_s[j][i][F-1:0], 1'b0};
				if (rem_n[i] >= {1'b0, len_s[j]}) begin
					rem_s[j+1][i] <= diff[i][W-1:0];
					q_s[j+1][i]   <= {q_s[j][i][F-1:0], 1'b1};
				end else begin
					rem_s[j+1][i] <= rem_n[i][W-1:0];
					q_s[j+1][i]   <= {q_s[j][i][F-1:0], 1'b0};
				end
			end
		end
	end

	assign ctrl_o = ctrl_s[F+1];
	assign len_o  = len_s[F+1];
	assign q_o    = q_s[F+1];
	assign side_o = side_s[F+1];

endmodule

FILE: src/vector3_arith_unit.sv
// ----------------------------------------------------------------------------
// vector3_arith_unit
// Fixed-point 3D vector ALU: add, subtract, scale, dot, length, normalise.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     start, taken if !busy     action three_d a_* b_* scale_factor
//  result    done, one cycle           res_x res_y res_z scalar_out saturated
//
//  One transaction accepted per cycle; busy is always low.
//  Every action takes the same path: 4 front stages, WORD_BITS
//  square-root stages, FRAC_BITS + 2 divider stages, one output register.
//  Reset clears all valid bits; the result side has no stall.
// ----------------------------------------------------------------------------
module vector3_arith_unit #(
	parameter int WORD_BITS = vau_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  action,
	input  logic                        three_d,
	input  logic signed [WORD_BITS-1:0] a_x,
	input  logic signed [WORD_BITS-1:0] a_y,
	input  logic signed [WORD_BITS-1:0] a_z,
	input  logic signed [WORD_BITS-1:0] b_x,
	input  logic signed [WORD_BITS-1:0] b_y,
	input  logic signed [WORD_BITS-1:0] b_z,
	input  logic signed [WORD_BITS-1:0] scale_factor,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] res_x,
	output logic signed [WORD_BITS-1:0] res_y,
	output logic signed [WORD_BITS-1:0] res_z,
	output logic signed [WORD_BITS-1:0] scalar_out,
	output logic                        saturated
);

	localparam int W    = WORD_BITS;
	localparam int F    = FRAC_BITS;
	localparam int XW   = 2*W + 2;
	localparam int SQ_SB = 7*W + 4;
	localparam int DV_SB = 4*W + 4;
	localparam int LAT  = W + F + 7;
	localparam logic signed [XW-1:0] MAXV = {{(W+3){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] MINV = {{(W+3){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [XW-1:0] ONE  = {{(XW-1){1'b0}}, 1'b1} << F;

	function automatic logic [W:0] sat_f(input logic signed [XW-1:0] x);
		if (x > MAXV) begin
			sat_f = {1'b1, MAXV[W-1:0]};
		end else if (x < MINV) begin
			sat_f = {1'b1, MINV[W-1:0]};
		end else begin
			sat_f = {1'b0, x[W-1:0]};
		end
	endfunction

	assign busy = 1'b0;

	vau_pkg::ctrl_t    f_ctrl, s_ctrl, d_ctrl;
	logic [2*W-1:0]    f_sq;
	logic [3:0][W-1:0] f_early;
	logic              f_flag;
	logic [2:0]        f_neg;
	logic [2:0][W-1:0] f_mag, s_mag;
	logic [W-1:0]      s_root, d_len;
	logic [SQ_SB-1:0]  s_side;
	logic [DV_SB-1:0]  d_side;
	logic [2:0][F:0]   d_q;

	vau_front #(.W(W), .F(F)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.action  (action),
		.three_d (three_d),
		.a       ({a_z, a_y, a_x}),
		.b       ({b_z, b_y, b_x}),
		.sf      (scale_factor),
		.ctrl_o  (f_ctrl),
		.sq_o    (f_sq),
		.early_o (f_early),
		.flag_o  (f_flag),
		.neg_o   (f_neg),
		.mag_o   (f_mag)
	);

	vau_sqrt #(.W(W), .SB_W(SQ_SB)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl_i (f_ctrl),
		.rad_i  (f_sq),
		.side_i ({f_early, f_flag, f_neg, f_mag}),
		.ctrl_o (s_ctrl),
		.root_o (s_root),
		.side_o (s_side)
	);

	assign s_mag = s_side[3*W-1:0];

	vau_div #(.W(W), .F(F), .SB_W(DV_SB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl_i (s_ctrl),
		.len_i  (s_root),
		.mag_i  (s_mag),
		.side_i (s_side[SQ_SB-1:3*W]),
		.ctrl_o (d_ctrl),
		.len_o  (d_len),
		.q_o    (d_q),
		.side_o (d_side)
	);

	logic [3:0][W-1:0] d_early, res_n;
	logic [2:0]        d_neg;
	logic              flag_n;
	logic [W:0]        t;
	logic signed [XW-1:0] qe;

	assign d_early = d_side[DV_SB-1:4];
	assign d_neg   = d_side[2:0];

	always_comb begin
		res_n  = d_early;
		flag_n = d_side[3];
		t      = '0;
		qe     = '0;
		if (d_ctrl.act == vau_pkg::ACT_LEN || d_ctrl.act == vau_pkg::ACT_NORM) begin
			res_n    = '0;
			t        = sat_f({{(XW-W){1'b0}}, d_len});
			res_n[3] = t[W-1:0];
			flag_n   = t[W];
			if (d_ctrl.act == vau_pkg::ACT_NORM) begin
				for (int i = 0; i < 3; i++) begin
					if (i < 2 || d_ctrl.d3) begin
						qe = {{(XW-F-1){1'b0}}, d_q[i]};
						if (d_len == '0) begin
							t = sat_f(ONE);
						end else if (d_neg[i]) begin
							t = sat_f(-qe);
						end else begin
							t = sat_f(qe);
						end
						res_n[i] = t[W-1:0];
						flag_n   = flag_n | t[W];
					end
				end
			end
		end
	end

	logic              done_q;
	logic [3:0][W-1:0] res_q;
	logic              sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d_ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_n;
		sat_q <= flag_n;
	end

	assign done       = done_q;
	assign res_x      = res_q[0];
	assign res_y      = res_q[1];
	assign res_z      = res_q[2];
	assign scalar_out = res_q[3];
	assign saturated  = sat_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("transaction did not complete at fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a transaction");

	a_flat_z: assert property (@(posedge clk) disable iff (!arst_n)
		done && !$past(three_d, LAT) |-> res_z == '0)
		else $error("z not zero in 2D mode");

	a_len_vec: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(action, LAT) == vau_pkg::ACT_LEN |->
		res_x == '0 && res_y == '0 && res_z == '0)
		else $error("vector fields not zero for length");

endmodule
